[hw/rtl/rmq_pkg.sv]
// Package for the rotation matrix to quaternion block.
// Holds the request and result structs, queue entry type, widths and the saturation helper.
`timescale 1ns / 1ps

package rmq_pkg;

  // default number of fraction bits of the matrix and quaternion fields
  localparam int FRAC_BITS_DEF = 14;
  // depth of the queue between front and back
  localparam int QDEPTH_DEF = 4;
  // width of the signed element sums inside the front
  localparam int CW = 34;
  // width of a component magnitude
  localparam int MW = 32;

  // branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_M00   = 2'd1;
  localparam logic [1:0] BR_M11   = 2'd2;
  localparam logic [1:0] BR_M22   = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         branch_used;
    logic               degenerate;
  } rmq_out_t;

  // classified request as it waits in the queue
  typedef struct packed {
    logic [1:0]          branch;
    logic                degen;
    logic [3:0]          neg;
    logic [3:0][MW-1:0]  mag;
    logic [MW-1:0]       mx;
  } rmq_entry_t;

  // signed saturation of a magnitude to 16 bits
  function automatic logic signed [15:0] sat16(input logic neg, input logic [MW-1:0] mag);
    logic [MW-1:0] nm;
    nm = ~mag + MW'(1);
    if (neg) begin
      sat16 = (mag > MW'(32768)) ? 16'sh8000 : $signed(nm[15:0]);
    end else begin
      sat16 = (mag > MW'(32767)) ? 16'sh7fff : $signed(mag[15:0]);
    end
  endfunction

endpackage

[hw/rtl/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion converter. The front classifies each request
// (branch, scaled components) in the cycle it is pushed and stores it in a small queue;
// the back works on one request at a time. For a non-degenerate request the back takes
// it from the queue, makes up to 29 one-bit normalizing shifts until the largest
// magnitude is in range, forms 4 squares through one multiplier, runs 32 square root
// steps and 4 divisions of 61 steps each, and loads the result register. A degenerate
// request skips to the result register. The queue absorbs a burst of QDEPTH requests;
// a finished result waits in the output register while the back goes on.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int QDEPTH    = QDEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  rmq_in_t  in_data,
  output logic     empty,
  input  logic     pop,
  output rmq_out_t out_data
);

  rmq_entry_t front_entry, q_data;
  logic       q_valid, q_rd, res_valid;

  // request classification
  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .req   (in_data),
    .entry (front_entry)
  );

  // queue between front and back
  rmq_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_data  (front_entry),
    .full     (full),
    .rd_en    (q_rd),
    .rd_data  (q_data),
    .rd_valid (q_valid)
  );

  // arithmetic and result register
  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_valid   (q_valid),
    .q_rd      (q_rd),
    .res       (out_data),
    .res_valid (res_valid),
    .res_pop   (pop)
  );

  assign empty = !res_valid;

endmodule

[hw/rtl/rmq_front.sv]
// Front of the rotation matrix to quaternion block: branch choice and scaled components.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_front
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  rmq_in_t    req,
  output rmq_entry_t entry
);

  logic signed [CW-1:0] one_s;
  logic signed [CW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [CW-1:0] trace, rad;
  logic signed [CW-1:0] q [4];
  logic [1:0]           br;
  logic [MW-1:0]        mg [4];
  logic [3:0]           ng;
  logic [MW-1:0]        mx01, mx23, mxa;

  assign one_s = $signed(CW'(64'(1) << FRAC_BITS));

  // sign extension of the elements
  assign e00 = CW'(req.m00);
  assign e01 = CW'(req.m01);
  assign e02 = CW'(req.m02);
  assign e10 = CW'(req.m10);
  assign e11 = CW'(req.m11);
  assign e12 = CW'(req.m12);
  assign e20 = CW'(req.m20);
  assign e21 = CW'(req.m21);
  assign e22 = CW'(req.m22);

  assign trace = e00 + e11 + e22;

  // branch choice
  always_comb begin
    if (trace > 0) begin
      br = BR_TRACE;
    end else if (req.m00 > req.m11 && req.m00 > req.m22) begin
      br = BR_M00;
    end else if (req.m11 > req.m22) begin
      br = BR_M11;
    end else begin
      br = BR_M22;
    end
  end

  // radicand and scaled components per branch
  always_comb begin
    case (br)
      BR_TRACE: begin
        rad  = one_s + trace;
        q[0] = e21 - e12;
        q[1] = e02 - e20;
        q[2] = e10 - e01;
        q[3] = rad;
      end
      BR_M00: begin
        rad  = one_s + e00 - e11 - e22;
        q[0] = rad;
        q[1] = e01 + e10;
        q[2] = e02 + e20;
        q[3] = e21 - e12;
      end
      BR_M11: begin
        rad  = one_s + e11 - e00 - e22;
        q[0] = e01 + e10;
        q[1] = rad;
        q[2] = e12 + e21;
        q[3] = e02 - e20;
      end
      default: begin
        rad  = one_s + e22 - e00 - e11;
        q[0] = e02 + e20;
        q[1] = e12 + e21;
        q[2] = rad;
        q[3] = e10 - e01;
      end
    endcase
  end

  // magnitudes and signs
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ng[i] = q[i][CW-1];
      mg[i] = ng[i] ? MW'(-q[i]) : MW'(q[i]);
    end
  end

  // largest magnitude
  assign mx01 = (mg[0] > mg[1]) ? mg[0] : mg[1];
  assign mx23 = (mg[2] > mg[3]) ? mg[2] : mg[3];
  assign mxa  = (mx01 > mx23) ? mx01 : mx23;

  always_comb begin
    entry.branch = br;
    entry.degen  = (rad <= 0) || (mxa == '0);
    entry.neg    = ng;
    for (int i = 0; i < 4; i++) begin
      entry.mag[i] = mg[i];
    end
    entry.mx = mxa;
  end

endmodule

[hw/rtl/rmq_queue.sv]
// Small queue of classified requests between the front and the back.
// Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_queue
  import rmq_pkg::*;
#(
  parameter int DEPTH = QDEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  rmq_entry_t wr_data,
  output logic       full,
  input  logic       rd_en,
  output rmq_entry_t rd_data,
  output logic       rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  rmq_entry_t    mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full     = (count_r == NW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + NW'(do_wr) - NW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(DEPTH))
    else $error("queue count beyond depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> count_r == $past(count_r) + NW'(1))
    else $error("queue count did not grow on write");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (do_rd && !do_wr) |=> count_r == $past(count_r) - NW'(1))
    else $error("queue count did not shrink on read");
`endif

endmodule

[hw/rtl/rmq_back.sv]
// Back of the rotation matrix to quaternion block: normalize, sum of squares,
// integer square root, per-component division and the result register. Depends on rmq_pkg.
`timescale 1ns / 1ps

module rmq_back
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  rmq_entry_t q_data,
  input  logic       q_valid,
  output logic       q_rd,
  output rmq_out_t   res,
  output logic       res_valid,
  input  logic       res_pop
);

  localparam logic signed [15:0] W_ID =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(32'(1) << FRAC_BITS);
  localparam int NUMW = 61;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NORM = 6'b000010,
    S_SQ   = 6'b000100,
    S_SQRT = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MW-1:0]     mag_r [4];
  logic [3:0]        neg_r;
  logic [1:0]        branch_r;
  logic              degen_r;
  logic [MW-1:0]     mx_r;
  logic [1:0]        idx_r, idx_nxt;
  logic [63:0]       acc_r, v_r, root_r, bit_r;
  logic [59:0]       prod;
  logic [63:0]       trial;
  logic [NUMW-1:0]   num_r;
  logic [32:0]       rem_r, rem_sh;
  logic [MW-1:0]     quot_r, quot_new;
  logic [5:0]        dcnt_r;
  logic signed [15:0] qout_r [4];
  logic              res_valid_r, res_valid_nxt;
  rmq_out_t          res_r;
  logic              load_out;
  logic              qbit;

  assign prod   = mag_r[idx_r][29:0] * mag_r[idx_r][29:0];
  assign trial  = root_r + bit_r;
  assign rem_sh = {rem_r[31:0], num_r[NUMW-1]};
  assign qbit   = (rem_sh >= {1'b0, root_r[31:0]});
  assign quot_new = {quot_r[MW-2:0], qbit};

  assign q_rd     = (state_r == S_IDLE) && q_valid;
  assign load_out = (state_r == S_DONE) && (!res_valid_r || res_pop);
  assign idx_nxt  = idx_r + 2'd1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = q_data.degen ? S_DONE : S_NORM;
      S_NORM: if (mx_r >= MW'(1 << 29) && mx_r < MW'(1 << 30)) state_nxt = S_SQ;
      S_SQ:   if (idx_r == 2'd3) state_nxt = S_SQRT;
      S_SQRT: if (bit_r == 64'd1) state_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 6'(NUMW - 1) && idx_r == 2'd3) state_nxt = S_DONE;
      S_DONE: if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          for (int i = 0; i < 4; i++) mag_r[i] <= q_data.mag[i];
          neg_r    <= q_data.neg;
          branch_r <= q_data.branch;
          degen_r  <= q_data.degen;
          mx_r     <= q_data.mx;
        end
      end
      S_NORM: begin
        // one bit of shift per cycle until the largest lies in [2^29, 2^30)
        if (mx_r < MW'(1 << 29)) begin
          for (int i = 0; i < 4; i++) mag_r[i] <= mag_r[i] << 1;
          mx_r <= mx_r << 1;
        end else if (mx_r >= MW'(1 << 30)) begin
          for (int i = 0; i < 4; i++) mag_r[i] <= mag_r[i] >> 1;
          mx_r <= mx_r >> 1;
        end else begin
          idx_r <= 2'd0;
          acc_r <= '0;
        end
      end
      S_SQ: begin
        // one square per cycle into the accumulator
        acc_r <= acc_r + 64'(prod);
        idx_r <= idx_nxt;
        if (idx_r == 2'd3) begin
          v_r    <= acc_r + 64'(prod);
          root_r <= '0;
          bit_r  <= 64'd1 << 62;
        end
      end
      S_SQRT: begin
        // one root bit per cycle
        if (v_r >= trial) begin
          v_r    <= v_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          idx_r  <= 2'd0;
          dcnt_r <= '0;
          rem_r  <= '0;
          quot_r <= '0;
          num_r  <= (NUMW'(mag_r[0]) << FRAC_BITS) +
                    NUMW'(((v_r >= trial) ? ((root_r >> 1) + bit_r) : (root_r >> 1)) >> 1);
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (dcnt_r == 6'(NUMW - 1)) begin
          qout_r[idx_r] <= sat16(neg_r[idx_r], quot_new);
          idx_r  <= idx_nxt;
          dcnt_r <= '0;
          rem_r  <= '0;
          quot_r <= '0;
          num_r  <= (NUMW'(mag_r[idx_nxt]) << FRAC_BITS) + NUMW'(root_r[31:1]);
        end else begin
          rem_r  <= qbit ? rem_sh - {1'b0, root_r[31:0]} : rem_sh;
          quot_r <= quot_new;
          num_r  <= num_r << 1;
          dcnt_r <= dcnt_r + 6'd1;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // result register
  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_pop) res_valid_nxt = 1'b0;
    if (load_out) res_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_r.branch_used <= branch_r;
      res_r.degenerate  <= degen_r;
      if (degen_r) begin
        res_r.quat_x <= '0;
        res_r.quat_y <= '0;
        res_r.quat_z <= '0;
        res_r.quat_w <= W_ID;
      end else begin
        res_r.quat_x <= qout_r[0];
        res_r.quat_y <= qout_r[1];
        res_r.quat_z <= qout_r[2];
        res_r.quat_w <= qout_r[3];
      end
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule

[test/tb_rotation_matrix_to_quaternion.sv]
// Testbench for the rotation matrix to quaternion converter.
// Drives matrix requests through the push/full queue, predicts each quaternion and checks pops.
// Depends on rmq_pkg and rotation_matrix_to_quaternion.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
  import rmq_pkg::*;

  localparam int FRAC = 14;
  localparam int N_RANDOM = 400;
  localparam longint CYCLE_LIMIT = 2000000;

  logic     clk;
  logic     rst_n;
  logic     push;
  logic     full;
  rmq_in_t  in_data;
  logic     empty;
  logic     pop;
  rmq_out_t out_data;

  rotation_matrix_to_quaternion dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  // expected quaternions in request order
  rmq_out_t quat_expected[$];
  int mismatch_count;
  longint cycle_count;
  bit stim_done;

  // directed table: matrix plus optional typed-in answer
  typedef struct {
    rmq_in_t  m;
    bit       has_ans;
    rmq_out_t ans;
  } dir_row_t;
  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(input bit neg, input longint unsigned mag);
    if (neg) return (mag > 32768) ? 16'sh8000 : 16'(-$signed({1'b0, mag[62:0]}));
    return (mag > 32767) ? 16'sh7fff : 16'(mag);
  endfunction

  // Shepperd branch choice, scaled components, normalize
  function automatic rmq_out_t matrix_to_quat(input rmq_in_t mi);
    longint one, tr, rad;
    longint e[9];
    longint q[4];
    longint unsigned mag[4];
    bit neg[4];
    longint unsigned mx, ssum, nrm, o;
    rmq_out_t r;
    one = longint'(1) << FRAC;
    e[0] = mi.m00; e[1] = mi.m01; e[2] = mi.m02;
    e[3] = mi.m10; e[4] = mi.m11; e[5] = mi.m12;
    e[6] = mi.m20; e[7] = mi.m21; e[8] = mi.m22;
    tr = e[0] + e[4] + e[8];
    if (tr > 0) begin
      r.branch_used = BR_TRACE;
      rad = one + tr;
      q[0] = e[7] - e[5]; q[1] = e[2] - e[6]; q[2] = e[3] - e[1]; q[3] = rad;
    end else if (e[0] > e[4] && e[0] > e[8]) begin
      r.branch_used = BR_M00;
      rad = one + e[0] - e[4] - e[8];
      q[0] = rad; q[1] = e[1] + e[3]; q[2] = e[2] + e[6]; q[3] = e[7] - e[5];
    end else if (e[4] > e[8]) begin
      r.branch_used = BR_M11;
      rad = one + e[4] - e[0] - e[8];
      q[0] = e[1] + e[3]; q[1] = rad; q[2] = e[5] + e[7]; q[3] = e[2] - e[6];
    end else begin
      r.branch_used = BR_M22;
      rad = one + e[8] - e[0] - e[4];
      q[0] = e[2] + e[6]; q[1] = e[5] + e[7]; q[2] = rad; q[3] = e[3] - e[1];
    end
    mx = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = q[i] < 0;
      mag[i] = neg[i] ? longint'(-q[i]) : q[i];
      if (mag[i] > mx) mx = mag[i];
    end
    // degenerate: identity
    if (rad <= 0 || mx == 0) begin
      r.quat_x = 0; r.quat_y = 0; r.quat_z = 0;
      r.quat_w = clamp16(1'b0, one);
      r.degenerate = 1'b1;
      return r;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
    end
    ssum = 0;
    for (int i = 0; i < 4; i++) ssum += mag[i] * mag[i];
    nrm = int_sqrt(ssum);
    for (int i = 0; i < 4; i++) begin
      o = (mag[i] * longint'(one) + (nrm >> 1)) / nrm;
      case (i)
        0: r.quat_x = clamp16(neg[i], o);
        1: r.quat_y = clamp16(neg[i], o);
        2: r.quat_z = clamp16(neg[i], o);
        default: r.quat_w = clamp16(neg[i], o);
      endcase
    end
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic rmq_in_t mk(input int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    rmq_in_t m;
    m.m00 = 16'(a0); m.m01 = 16'(a1); m.m02 = 16'(a2);
    m.m10 = 16'(a3); m.m11 = 16'(a4); m.m12 = 16'(a5);
    m.m20 = 16'(a6); m.m21 = 16'(a7); m.m22 = 16'(a8);
    return m;
  endfunction

  function automatic rmq_out_t ans(input int x, y, z, w, input logic [1:0] br, input bit dg);
    rmq_out_t r;
    r.quat_x = 16'(x); r.quat_y = 16'(y); r.quat_z = 16'(z); r.quat_w = 16'(w);
    r.branch_used = br; r.degenerate = dg;
    return r;
  endfunction

  task automatic add_row(input rmq_in_t m, input bit has, input rmq_out_t a);
    dir_row_t d;
    d.m = m; d.has_ans = has; d.ans = a;
    dir_rows.push_back(d);
  endtask

  // random matrix: mostly rotation-like, some noise
  function automatic rmq_in_t rand_matrix();
    rmq_in_t m;
    int k;
    m = rmq_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    k = $urandom_range(0, 9);
    if (k < 6) begin
      // near-orthonormal: permutation with signs plus small noise
      int p, s0, s1, s2, sel;
      int v[9];
      p = $urandom_range(0, 2);
      sel = $urandom_range(0, 1);
      for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 4000) - 2000;
      s0 = $urandom_range(0, 1) ? 16384 : -16384;
      s1 = $urandom_range(0, 1) ? 16384 : -16384;
      s2 = $urandom_range(0, 1) ? 16384 : -16384;
      if (sel == 0) begin
        v[0] += s0; v[4] += s1; v[8] += s2;
      end else begin
        v[(p + 1) % 3] += s0; v[3 + (p + 2) % 3] += s1; v[6 + p] += s2;
      end
      m = mk(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    end else if (k < 8) begin
      // small elements to hit tiny radicands and zero components
      m = mk($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
             $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
             $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
    end
    return m;
  endfunction

  task automatic send(input rmq_in_t m);
    push <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (full) @(posedge clk);
    quat_expected.push_back(matrix_to_quat(m));
  endtask

  // idle gap between bursts
  task automatic maybe_gap(inout int burst);
    int g;
    if (burst > 0) begin
      burst--;
      return;
    end
    burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    g = $urandom_range(0, 4);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    int burst;
    rst_n = 1'b0;
    push = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    burst = 0;
    // identity and half-turns about each axis
    add_row(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1, ans(0, 0, 0, 16384, BR_TRACE, 0));
    add_row(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1, ans(16384, 0, 0, 0, BR_M00, 0));
    add_row(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1, ans(0, 16384, 0, 0, BR_M11, 0));
    add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1, ans(0, 0, 16384, 0, BR_M22, 0));
    // all-zero matrix: radicand one, components zero except largest
    add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    // all-negative diagonals: ties fall to the m22 branch
    add_row(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0, '0);
    add_row(mk(-32768, 32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768), 0, '0);
    add_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 0, '0);
    // extremes of every field
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 0, '0);
    add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768), 0, '0);
    add_row(mk(32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767), 0, '0);
    add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768), 0, '0);
    // ties in the diagonal fall through to later branches
    add_row(mk(-100, 5, 9, -7, -100, 3, 2, -1, -100), 0, '0);
    add_row(mk(-50, 5, 9, -7, -50, 3, 2, -1, -200), 0, '0);
    // quarter turn about z
    add_row(mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384), 0, '0);
    add_row(mk(1, -1, 1, -1, 1, -1, 1, -1, -3), 0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].m);
      if (dir_rows[i].has_ans) begin
        rmq_out_t p;
        p = quat_expected[$];
        if (p !== dir_rows[i].ans) $display("directed row %0d: table answer differs", i);
        quat_expected[$] = dir_rows[i].ans;
      end
      maybe_gap(burst);
    end

    // hold off until the pipeline drains
    push <= 1'b0;
    while (quat_expected.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      send(rand_matrix());
      maybe_gap(burst);
    end
    push <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern: long runs of ready, then stalls
  initial begin
    int phase;
    pop = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase = (phase + 1) % 64;
      if (phase < 24) pop <= 1'b1;
      else pop <= ($urandom_range(0, 2) != 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
    end
  end

  // pop check
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (quat_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected quaternion %p", out_data);
      end else begin
        rmq_out_t e;
        e = quat_expected.pop_front();
        if (out_data !== e) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("expected %p got %p", e, out_data);
        end
      end
    end
  end

  // end of run and timeout
  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    fork
      begin
        wait (stim_done);
        while (quat_expected.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && quat_expected.size() == 0) begin
          $display("No mismatches found");
        end else begin
          $display("Mismatches found");
        end
        $finish;
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk);
          cycle_count++;
        end
        $display("Mismatches found");
        $finish;
      end
    join
  end

endmodule

[filelist.f]
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_queue.sv
hw/rtl/rmq_back.sv
hw/rtl/rotation_matrix_to_quaternion.sv
test/tb_rotation_matrix_to_quaternion.sv
